// ===== design/sfr_pkg.sv =====
package sfr_pkg;

   // Field widths fixed by the result format
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int INDEX_W = 6;
   localparam int LEN_W   = 7;

   // Configuration bus
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   // Register index, taken from the word address bit
   localparam logic REG_MARKER     = 1'b0;
   localparam logic REG_ERRORS_EN  = 1'b1;

   localparam logic [BYTE_W-1:0] MARKER_RESET    = 8'h7E;
   localparam logic              ERRORS_EN_RESET = 1'b1;

   // Result kinds
   localparam logic [KIND_W-1:0] EV_FRAME_BYTE = 2'd0;
   localparam logic [KIND_W-1:0] EV_CHECKSUM   = 2'd1;
   localparam logic [KIND_W-1:0] EV_LENGTH     = 2'd2;

   // Length coding of the first frame byte
   localparam logic [BYTE_W-1:0] SHORT_LEN_MIN  = 8'hC0;
   localparam logic [BYTE_W-1:0] SHORT_LEN_MASK = 8'h30;
   localparam logic [LEN_W-1:0]  DEFAULT_LEN    = 7'd2;
   localparam logic [BYTE_W:0]   LONG_LEN_BIAS  = 9'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] marker;
      logic              errors_en;
   } cfg_type;

   typedef struct packed {
      logic process;   // accept the presented byte
      logic advance;   // move readout to the next stored byte
   } cmd_type;

   typedef struct packed {
      logic emit;      // presented byte produces results
      logic last;      // current result closes the burst
   } status_type;

endpackage

// ===== design/sfr_ram.sv =====
module sfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sfr_csr.sv =====
module sfr_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [sfr_pkg::ADDR_W-1:0]   paddr,
   input  logic [sfr_pkg::DATA_W-1:0]   pwdata,
   output logic [sfr_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output sfr_pkg::cfg_type             cfg
);

   logic [sfr_pkg::BYTE_W-1:0] marker_ff, marker_in;
   logic                       errors_en_ff, errors_en_in;
   logic                       write_strobe;
   logic                       reg_index;

   assign pready       = 1'b1;
   assign write_strobe = psel & penable & pwrite;
   assign reg_index    = paddr[2];

   always_comb begin
      marker_in    = marker_ff;
      errors_en_in = errors_en_ff;
      if (write_strobe) begin
         unique case (reg_index)
            sfr_pkg::REG_MARKER:    marker_in    = pwdata[sfr_pkg::BYTE_W-1:0];
            sfr_pkg::REG_ERRORS_EN: errors_en_in = pwdata[0];
            default:                marker_in    = marker_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         sfr_pkg::REG_MARKER:    prdata = sfr_pkg::DATA_W'(marker_ff);
         sfr_pkg::REG_ERRORS_EN: prdata = sfr_pkg::DATA_W'(errors_en_ff);
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff    <= sfr_pkg::MARKER_RESET;
         errors_en_ff <= sfr_pkg::ERRORS_EN_RESET;
      end else begin
         marker_ff    <= marker_in;
         errors_en_ff <= errors_en_in;
      end
   end

   assign cfg.marker    = marker_ff;
   assign cfg.errors_en = errors_en_ff;

endmodule

// ===== design/sfr_datapath.sv =====
module sfr_datapath #(
   parameter int BUFFER_BYTES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sfr_pkg::cfg_type              cfg,
   input  sfr_pkg::cmd_type              cmd,
   output sfr_pkg::status_type           status,
   input  logic [sfr_pkg::BYTE_W-1:0]    rx_byte,
   output logic [sfr_pkg::KIND_W-1:0]    event_kind,
   output logic [sfr_pkg::BYTE_W-1:0]    frame_byte,
   output logic [sfr_pkg::INDEX_W-1:0]   byte_index,
   output logic [sfr_pkg::LEN_W-1:0]     frame_length,
   output logic                          last_of_frame
);

   localparam int AW = $clog2(BUFFER_BYTES);

   logic                         after_marker_ff, after_marker_in;
   logic                         in_frame_ff, in_frame_in;
   logic                         length_known_ff, length_known_in;
   logic [sfr_pkg::BYTE_W-1:0]   sum_ff, sum_in;
   logic [sfr_pkg::LEN_W-1:0]    wr_pos_ff, wr_pos_in;
   logic [sfr_pkg::LEN_W-1:0]    exp_len_ff, exp_len_in;
   logic [AW-1:0]                rd_idx_ff, rd_idx_in;
   logic [sfr_pkg::KIND_W-1:0]   kind_ff, kind_in;

   logic                         is_marker, to_frame, open_frame, in_data;
   logic                         store_byte, check_byte, is_short;
   logic                         bad_len, sum_bad, deliver;
   logic [sfr_pkg::BYTE_W-1:0]   sum_add;
   logic [sfr_pkg::BYTE_W:0]     long_len;
   logic [sfr_pkg::LEN_W-1:0]    short_len;
   logic                         is_frame_kind;

   logic                         ram_wr_en, ram_rd_en;
   logic [AW-1:0]                ram_wr_addr, ram_rd_addr;
   logic [sfr_pkg::BYTE_W-1:0]   ram_rd_data;

   // A marker arms the escape; a doubled marker is data, anything else opens a frame
   assign is_marker  = (rx_byte == cfg.marker);
   assign to_frame   = after_marker_ff ? is_marker : ~is_marker;
   assign open_frame = after_marker_ff & ~is_marker;
   assign in_data    = to_frame & in_frame_ff;
   assign store_byte = in_data & (wr_pos_ff != exp_len_ff);
   assign check_byte = in_data & (wr_pos_ff == exp_len_ff);

   assign sum_add   = sum_ff + rx_byte;
   assign long_len  = {1'b0, rx_byte} + sfr_pkg::LONG_LEN_BIAS;
   assign short_len = sfr_pkg::LEN_W'((rx_byte & sfr_pkg::SHORT_LEN_MASK) >> 3) + 7'd1;
   assign is_short  = (rx_byte >= sfr_pkg::SHORT_LEN_MIN);

   assign bad_len = store_byte & ~length_known_ff &
                    (long_len > (sfr_pkg::BYTE_W + 1)'(BUFFER_BYTES));
   assign sum_bad = check_byte & (sum_add != '0);
   assign deliver = check_byte & (sum_add == '0);

   assign is_frame_kind = (kind_ff == sfr_pkg::EV_FRAME_BYTE);

   assign status.emit = deliver | ((bad_len | sum_bad) & cfg.errors_en);
   assign status.last = ~is_frame_kind |
                        ((sfr_pkg::LEN_W'(rd_idx_ff) + 7'd1) == exp_len_ff);

   always_comb begin
      after_marker_in = after_marker_ff;
      in_frame_in     = in_frame_ff;
      length_known_in = length_known_ff;
      sum_in          = sum_ff;
      wr_pos_in       = wr_pos_ff;
      exp_len_in      = exp_len_ff;
      rd_idx_in       = rd_idx_ff;
      kind_in         = kind_ff;
      if (cmd.process) begin
         after_marker_in = ~after_marker_ff & is_marker;
         if (open_frame) begin
            in_frame_in     = 1'b1;
            sum_in          = rx_byte;
            wr_pos_in       = 7'd1;
            length_known_in = is_short;
            exp_len_in      = is_short ? short_len : sfr_pkg::DEFAULT_LEN;
         end else if (store_byte) begin
            wr_pos_in = wr_pos_ff + 7'd1;
            sum_in    = sum_add;
            if (!length_known_ff) begin
               exp_len_in      = long_len[sfr_pkg::LEN_W-1:0];
               length_known_in = 1'b1;
               if (bad_len) begin
                  in_frame_in = 1'b0;
               end
            end
         end else if (check_byte) begin
            sum_in      = sum_add;
            in_frame_in = 1'b0;
         end
         if (deliver) begin
            kind_in   = sfr_pkg::EV_FRAME_BYTE;
            rd_idx_in = '0;
         end else if (sum_bad) begin
            kind_in = sfr_pkg::EV_CHECKSUM;
         end else if (bad_len) begin
            kind_in = sfr_pkg::EV_LENGTH;
         end
      end
      if (cmd.advance) begin
         rd_idx_in = AW'(rd_idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_marker_ff <= 1'b0;
         in_frame_ff     <= 1'b0;
         length_known_ff <= 1'b0;
         sum_ff          <= '0;
         wr_pos_ff       <= '0;
         exp_len_ff      <= '0;
         rd_idx_ff       <= '0;
         kind_ff         <= sfr_pkg::EV_FRAME_BYTE;
      end else begin
         after_marker_ff <= after_marker_in;
         in_frame_ff     <= in_frame_in;
         length_known_ff <= length_known_in;
         sum_ff          <= sum_in;
         wr_pos_ff       <= wr_pos_in;
         exp_len_ff      <= exp_len_in;
         rd_idx_ff       <= rd_idx_in;
         kind_ff         <= kind_in;
      end
   end

   // Frame store: written while a frame fills, read back one byte per result
   assign ram_wr_en   = cmd.process & (open_frame | store_byte);
   assign ram_wr_addr = open_frame ? '0 : wr_pos_ff[AW-1:0];
   assign ram_rd_en   = (cmd.process & deliver) | cmd.advance;
   assign ram_rd_addr = cmd.advance ? AW'(rd_idx_ff + 1'b1) : '0;

   sfr_ram #(
      .WIDTH (sfr_pkg::BYTE_W),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (rx_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign event_kind    = kind_ff;
   assign frame_byte    = is_frame_kind ? ram_rd_data : '0;
   assign byte_index    = is_frame_kind ? sfr_pkg::INDEX_W'(rd_idx_ff) : '0;
   assign frame_length  = is_frame_kind ? exp_len_ff : '0;
   assign last_of_frame = status.last;

   a_pos_within_len: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (wr_pos_ff <= exp_len_ff))
      else $error("write position ran past the frame length");

   a_len_fits_store: assert property (@(posedge clock) disable iff (reset)
      (in_frame_ff && length_known_ff) |-> (exp_len_ff <= sfr_pkg::LEN_W'(BUFFER_BYTES)))
      else $error("open frame longer than the store");

endmodule

// ===== design/sfr_ctrl.sv =====
module sfr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sfr_pkg::cmd_type      cmd,
   input  sfr_pkg::status_type   status
);

   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } state_type;

   state_type state_ff;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_SEND);
   assign cmd.process = req_valid & req_ready;
   assign cmd.advance = rsp_valid & rsp_ready & ~status.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.process && status.emit) begin
                  state_ff <= ST_SEND;
               end
            end
            ST_SEND: begin
               if (rsp_ready && status.last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_result_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result raised without an accepted byte");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !status.last) |=> rsp_valid)
      else $error("readout stopped before the last byte");

endmodule

// ===== design/stuffed_frame_receiver.sv =====
// Byte-stuffed frame receiver with an 8-bit sum check.
// Input channel (req_): one raw line byte per transfer on req_rx_byte.
// Result channel (rsp_): one transfer per delivered frame byte, or one per
//   reported error (checksum or illegal length); rsp_last_of_frame marks the
//   final transfer caused by one input byte.
// Config (APB): marker byte at address 0, error-report enable at address 4.
//   Write only while the block is idle.
// Throughput: one input byte per cycle while no result is pending. The byte
//   that closes a good frame of N bytes starts a readout of N transfers, one
//   per cycle while rsp_ready is high, set by the single read port of the frame
//   store; intake holds until the last of them is taken. An error result holds
//   intake for one transfer.
// Latency: the first result appears in the cycle after the closing byte is
//   accepted (registered store read).
// Reset clears the deframing state and loads marker 0x7E and reporting on;
//   the frame store is not cleared and needs no clearing pass.
// When the receiver stalls (rsp_ready low), hold the current result and keep
//   req_ready low; nothing is dropped.
module stuffed_frame_receiver #(
   parameter int BUFFER_BYTES = 64
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sfr_pkg::BYTE_W-1:0]    req_rx_byte,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sfr_pkg::KIND_W-1:0]    rsp_event_kind,
   output logic [sfr_pkg::BYTE_W-1:0]    rsp_frame_byte,
   output logic [sfr_pkg::INDEX_W-1:0]   rsp_byte_index,
   output logic [sfr_pkg::LEN_W-1:0]     rsp_frame_length,
   output logic                          rsp_last_of_frame,

   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sfr_pkg::ADDR_W-1:0]    paddr,
   input  logic [sfr_pkg::DATA_W-1:0]    pwdata,
   output logic [sfr_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   sfr_pkg::cfg_type     cfg;
   sfr_pkg::cmd_type     cmd;
   sfr_pkg::status_type  status;

   // Configuration registers
   sfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Handshake and readout sequencing
   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Deframing state, running sum and frame store
   sfr_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .status        (status),
      .rx_byte       (req_rx_byte),
      .event_kind    (rsp_event_kind),
      .frame_byte    (rsp_frame_byte),
      .byte_index    (rsp_byte_index),
      .frame_length  (rsp_frame_length),
      .last_of_frame (rsp_last_of_frame)
   );

endmodule
